>>> src/hcbp_pkg.sv
// Shared types, opcodes and constants for the variable-length code packer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package hcbp_pkg;

  localparam int BYTE_W           = 8;
  localparam int SYM_W            = 8;
  localparam int TABLE_DEPTH      = 1 << SYM_W;
  localparam int LEN_FIELD_W      = 6;
  localparam int CODE_FIELD_W     = 32;
  localparam int PEND_W           = 7;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [SYM_W-1:0]        symbol;
    logic [LEN_FIELD_W-1:0]  code_length;
    logic [CODE_FIELD_W-1:0] code_bits;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } pack_state_t;

endpackage

`default_nettype wire

>>> src/hcbp_table.sv
// Code table: one entry of saturated length and masked code per symbol.
// Single write port and one registered read port; uses hcbp_pkg.
`default_nettype none

module hcbp_table import hcbp_pkg::*; #(
  parameter int CODE_W = MAX_CODE_LEN_DEF,
  parameter int LEN_W  = $clog2(CODE_W + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [SYM_W-1:0]        wr_idx,
  input  wire logic [LEN_FIELD_W-1:0]  wr_length,
  input  wire logic [CODE_FIELD_W-1:0] wr_bits,
  input  wire logic [SYM_W-1:0]        rd_idx,
  output logic      [LEN_W-1:0]        rd_length,
  output logic      [CODE_W-1:0]       rd_code
);

  logic [LEN_W+CODE_W-1:0] mem [TABLE_DEPTH];
  logic [LEN_W+CODE_W-1:0] rd_r;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W-1:0]       code_mask;

  // Lengths beyond the storable code width saturate; the mask then keeps all bits.
  always_comb begin
    if ({1'b0, wr_length} > (LEN_FIELD_W + 1)'(CODE_W)) begin
      len_sat = LEN_W'(CODE_W);
    end else begin
      len_sat = wr_length[LEN_W-1:0];
    end
    code_mask = ~({CODE_W{1'b1}} << wr_length);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {len_sat, wr_bits[CODE_W-1:0] & code_mask};
    end
    rd_r <= mem[rd_idx];
  end

  assign rd_length = rd_r[LEN_W+CODE_W-1:CODE_W];
  assign rd_code   = rd_r[CODE_W-1:0];

endmodule

`default_nettype wire

>>> src/hcbp_extract.sv
// Shared byte extractor: takes the top byte of the valid bits of the
// accumulator and masks off what was taken. Uses hcbp_pkg.
`default_nettype none

module hcbp_extract import hcbp_pkg::*; #(
  parameter int ACC_W = MAX_CODE_LEN_DEF + PEND_W,
  parameter int TOT_W = $clog2(ACC_W + 1)
) (
  input  wire logic [ACC_W-1:0]  acc,
  input  wire logic [TOT_W-1:0]  total,
  output logic      [BYTE_W-1:0] byte_val,
  output logic      [ACC_W-1:0]  rem_acc,
  output logic      [TOT_W-1:0]  rem_total
);

  logic [ACC_W-1:0] shifted;

  // The caller only uses this with at least one full byte in the accumulator.
  always_comb begin
    rem_total = total - TOT_W'(BYTE_W);
    shifted   = acc >> rem_total;
    byte_val  = shifted[BYTE_W-1:0];
    rem_acc   = acc & ~({ACC_W{1'b1}} << rem_total);
  end

endmodule

`default_nettype wire

>>> src/huffman_code_bit_packer_unit.sv
// Top level of the variable-length code packer: sequencer, bit accumulator
// and output register. Uses hcbp_pkg, hcbp_table and hcbp_extract.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall | out_data (out_item_t)
//
// A load writes one table entry. An encode reads the table, merges the code
// and emits each completed byte; the single byte extractor yields one byte
// per cycle, and output stalls hold the byte loop. A non-empty flush pads and
// emits the pending bits as one last byte; an empty flush does nothing.
// Reset clears the accumulator and the sequencer; table contents stay
// undefined until loaded.
`default_nettype none

module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int ACC_W  = CODE_W + PEND_W;
  localparam int TOT_W  = $clog2(ACC_W + 1);

  pack_state_t       state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              flush_r, flush_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              out_free;
  logic [LEN_W-1:0]  rd_length;
  logic [CODE_W-1:0] rd_code;
  logic [ACC_W-1:0]  merge_acc;
  logic [TOT_W-1:0]  merge_total;
  logic [BYTE_W-1:0] ext_byte;
  logic [ACC_W-1:0]  ext_acc;
  logic [TOT_W-1:0]  ext_total;
  logic              ext_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hcbp_table #(
    .CODE_W (CODE_W),
    .LEN_W  (LEN_W)
  ) u_table (
    .clk       (clk),
    .wr_en     (in_xfer && (in_data.opcode == OP_LOAD)),
    .wr_idx    (in_data.symbol),
    .wr_length (in_data.code_length),
    .wr_bits   (in_data.code_bits),
    .rd_idx    (in_data.symbol),
    .rd_length (rd_length),
    .rd_code   (rd_code)
  );

  hcbp_extract #(
    .ACC_W (ACC_W),
    .TOT_W (TOT_W)
  ) u_extract (
    .acc       (acc_r),
    .total     (total_r),
    .byte_val  (ext_byte),
    .rem_acc   (ext_acc),
    .rem_total (ext_total)
  );

  // Between items the accumulator holds only the pending bits, so the
  // shift cannot push anything out of range.
  assign merge_acc   = (acc_r << rd_length) | ACC_W'(rd_code);
  assign merge_total = total_r + TOT_W'(rd_length);
  assign ext_last    = (ext_total < TOT_W'(BYTE_W));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.opcode == OP_ENCODE)) begin
          state_nxt = ST_MERGE;
        end else if (in_xfer && (in_data.opcode == OP_FLUSH) && (total_r != '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MERGE: begin
        if (merge_total >= TOT_W'(BYTE_W)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && ext_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    flush_nxt     = flush_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        // A flush appends eight zero bits so that the extractor yields the
        // pending bits left-aligned and padded.
        if (in_xfer && (in_data.opcode == OP_FLUSH) && (total_r != '0)) begin
          acc_nxt   = acc_r << BYTE_W;
          total_nxt = total_r + TOT_W'(BYTE_W);
          flush_nxt = 1'b1;
        end
      end
      ST_MERGE: begin
        acc_nxt   = merge_acc;
        total_nxt = merge_total;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_byte  = ext_byte;
          out_data_nxt.last_byte = ext_last;
          acc_nxt                = ext_acc;
          total_nxt              = ext_total;
          if (ext_last && flush_r) begin
            acc_nxt   = '0;
            total_nxt = '0;
            flush_nxt = 1'b0;
          end
        end
      end
      default: begin
        flush_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      total_r     <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      total_r     <= total_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (total_r < TOT_W'(BYTE_W)))
    else $error("pending bit count reached a full byte while idle");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((acc_r >> total_r) == '0))
    else $error("accumulator holds bits above the pending count");

  a_flush_emit: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (state_r == ST_EMIT))
    else $error("flush marker outside the byte loop");

  a_emit_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_free) |=> out_valid)
    else $error("byte loop advanced without presenting a byte");
`endif

endmodule

`default_nettype wire
